FILE: rtl/core/rhcsf_pkg.sv
// shared types and constants for the rolling hash chunker
package rhcsf_pkg;

  localparam int REGIONS = 12;

  // configuration register indexes
  localparam logic [2:0] CFG_HASH_MULT  = 3'd0;
  localparam logic [2:0] CFG_DROP       = 3'd1;
  localparam logic [2:0] CFG_CHUNK      = 3'd2;
  localparam logic [2:0] CFG_WEIGHT_0   = 3'd3;
  localparam logic [2:0] CFG_WEIGHT_1   = 3'd4;
  localparam logic [2:0] CFG_WEIGHT_2   = 3'd5;
  localparam logic [2:0] CFG_WEIGHT_3   = 3'd6;

  // one classified byte handed from front to back
  typedef struct packed {
    logic [7:0]  data;
    logic [7:0]  old;
    logic [15:0] fill;
    logic        last;
    logic [47:0] start;
  } word_t;

  // configuration seen by the back end
  typedef struct packed {
    logic [63:0]      mult;
    logic [63:0]      drop;
    logic [15:0]      span;
    logic [3:0][63:0] weight;
  } cfg_t;

  typedef enum logic {F_RDY, F_WAIT} front_state_t;

  typedef enum logic [2:0] {B_IDLE, B_MUL, B_UPD, B_FEAT, B_DRAIN} back_state_t;

endpackage

FILE: rtl/core/rhcsf_front.sv
// front end: takes bytes, runs the window store and chunk counters
module rhcsf_front import rhcsf_pkg::*; #(
  parameter int WINDOW_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic [15:0] chunk_bytes,
  input  logic        q_full,
  output logic        q_push,
  output word_t       q_wdata
);

  localparam int SLOT_W = (WINDOW_BYTES > 1) ? $clog2(WINDOW_BYTES) : 1;

  front_state_t state_r, state_nxt;
  logic [7:0]        mem [WINDOW_BYTES];
  logic [WINDOW_BYTES-1:0] vld_r;
  logic [7:0]        rd_r;
  logic              vrd_r;
  logic [SLOT_W-1:0] slot_r;
  logic [15:0]       fill_r, fill_nxt;
  logic [47:0]       seen_r, seen_nxt;
  logic              last;

  assign fill_nxt = fill_r + 16'd1;
  assign seen_nxt = seen_r + 48'd1;
  assign last     = (fill_nxt == chunk_bytes);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_RDY:  if (q_push) state_nxt = F_WAIT;
      F_WAIT: state_nxt = F_RDY;
      default: state_nxt = F_RDY;
    endcase
  end

  // outputs
  always_comb begin
    in_stall = 1'b1;
    unique case (state_r)
      F_RDY:  in_stall = q_full;
      F_WAIT: in_stall = 1'b1;
      default: in_stall = 1'b1;
    endcase
  end

  assign q_push        = in_valid && !in_stall;
  assign q_wdata.data  = in_data_byte;
  assign q_wdata.old   = vrd_r ? rd_r : 8'd0;
  assign q_wdata.fill  = fill_r;
  assign q_wdata.last  = last;
  assign q_wdata.start = seen_nxt - {32'd0, fill_nxt};

  // window memory, registered read at the current slot
  always_ff @(posedge clk) begin
    if (q_push) mem[slot_r] <= in_data_byte;
    rd_r <= mem[slot_r];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_RDY;
      vld_r   <= '0;
      vrd_r   <= 1'b0;
      slot_r  <= '0;
      fill_r  <= '0;
      seen_r  <= '0;
    end else begin
      state_r <= state_nxt;
      vrd_r   <= vld_r[slot_r];
      if (q_push) begin
        vld_r[slot_r] <= 1'b1;
        slot_r <= (slot_r == SLOT_W'(WINDOW_BYTES - 1)) ? '0 : slot_r + 1'b1;
        fill_r <= last ? 16'd0 : fill_nxt;
        seen_r <= seen_nxt;
      end
    end
  end

endmodule

FILE: rtl/core/rhcsf_queue.sv
// two-entry queue between front and back
module rhcsf_queue import rhcsf_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  word_t wdata,
  input  logic  pop,
  output word_t rdata,
  output logic  full,
  output logic  empty
);

  word_t      ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = ent_r[rp_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= wdata;
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: rtl/core/rhcsf_back.sv
// back end: hash updates, region maxima and super-features on a shared multiplier
module rhcsf_back import rhcsf_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  cfg_t         cfg,
  input  logic         q_empty,
  input  word_t        q_rdata,
  output logic         q_pop,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [47:0]  out_chunk_start,
  output logic [63:0]  out_chunk_hash,
  output logic [63:0]  out_super_feature_0,
  output logic [63:0]  out_super_feature_1,
  output logic [63:0]  out_super_feature_2
);

  back_state_t state_r, state_nxt;
  word_t       cur_r;
  logic [63:0] roll_r, chunk_r;
  logic [63:0] max_r [REGIONS];
  logic [63:0] acc_r [3];
  logic [3:0]  item_r, cnt_r, region_r;
  logic [1:0]  part_r;
  logic [16:0] thr_r;
  logic        out_valid_r;
  logic [47:0] out_start_r;
  logic [63:0] out_hash_r;
  logic [63:0] out_sf_r [3];
  logic        out_load;
  // multiplier pipe
  logic [63:0] prod_r;
  logic        tag_v_r, tag_sh_r, tag_sub_r;
  logic [1:0]  tag_i_r;
  // issue decode
  logic        issue, step_done;
  logic [63:0] op_a, op_b, add_val;
  logic [1:0]  op_i;
  logic        op_sub;
  logic [31:0] mx, my;

  // result moves to the output registers once the last feature add has landed
  assign out_load = (state_r == B_DRAIN) && !tag_v_r && (!out_valid_r || !out_stall);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE:  if (!q_empty) state_nxt = B_MUL;
      B_MUL:   if (cnt_r == 4'd11) state_nxt = B_UPD;
      B_UPD:   state_nxt = cur_r.last ? B_FEAT : B_IDLE;
      B_FEAT:  if (item_r == 4'd11 && part_r == 2'd2) state_nxt = B_DRAIN;
      B_DRAIN: if (out_load) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_pop = 1'b0;
    issue = 1'b0;
    unique case (state_r)
      B_IDLE:  q_pop = !q_empty;
      B_MUL:   issue = (item_r < 4'd3);
      B_FEAT:  issue = 1'b1;
      B_UPD, B_DRAIN: issue = 1'b0;
      default: issue = 1'b0;
    endcase
  end

  // operand selection
  always_comb begin
    op_a   = 64'd0;
    op_b   = 64'd0;
    op_i   = 2'd0;
    op_sub = 1'b0;
    if (state_r == B_FEAT) begin
      op_a = max_r[0];
      op_b = cfg.weight[item_r[1:0]];
      op_i = item_r[3:2];
    end else begin
      case (item_r)
        4'd0: begin op_a = roll_r; op_b = cfg.mult; end
        4'd1: begin op_a = chunk_r; op_b = cfg.mult; op_i = 2'd1; end
        default: begin
          op_a = {{56{cur_r.old[7]}}, cur_r.old};
          op_b = cfg.drop;
          op_sub = 1'b1;
        end
      endcase
    end
  end

  // low and high halves per partial product
  assign mx = (part_r == 2'd2) ? op_a[63:32] : op_a[31:0];
  assign my = (part_r == 2'd1) ? op_b[63:32] : op_b[31:0];
  assign step_done = (part_r == 2'd2);
  assign add_val = tag_sh_r ? {prod_r[31:0], 32'd0} : prod_r;

  // multiplier pipe register
  always_ff @(posedge clk) begin
    prod_r    <= {32'd0, mx} * {32'd0, my};
    tag_sh_r  <= (part_r != 2'd0);
    tag_sub_r <= op_sub;
    tag_i_r   <= op_i;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (tag_v_r) begin
      acc_r[tag_i_r] <= tag_sub_r ? acc_r[tag_i_r] - add_val : acc_r[tag_i_r] + add_val;
    end
    if (q_pop) begin
      cur_r    <= q_rdata;
      acc_r[0] <= {{56{q_rdata.data[7]}}, q_rdata.data};
      acc_r[1] <= {{56{q_rdata.data[7]}}, q_rdata.data};
    end
    if (state_r == B_UPD && cur_r.last) begin
      acc_r[0] <= 64'd0;
      acc_r[1] <= 64'd0;
      acc_r[2] <= 64'd0;
    end
    // output word registers
    if (out_load) begin
      out_start_r <= cur_r.start;
      out_hash_r  <= chunk_r;
      out_sf_r[0] <= acc_r[0];
      out_sf_r[1] <= acc_r[1];
      out_sf_r[2] <= acc_r[2];
    end
  end

  // control, hash state and region maxima
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      item_r      <= '0;
      part_r      <= '0;
      cnt_r       <= '0;
      region_r    <= '0;
      thr_r       <= '0;
      tag_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
      roll_r      <= '0;
      chunk_r     <= '0;
      for (int i = 0; i < REGIONS; i++) max_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      tag_v_r <= issue;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (issue) begin
        part_r <= step_done ? 2'd0 : part_r + 2'd1;
        if (step_done) item_r <= item_r + 4'd1;
      end
      // region index search, one threshold per cycle
      if (state_r == B_MUL) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r < 4'd11) begin
          if ({1'b0, cur_r.fill} >= thr_r) region_r <= region_r + 4'd1;
          thr_r <= thr_r + {1'b0, cfg.span};
        end
      end
      // shift maxima out during features, zeros fill behind
      if (state_r == B_FEAT && step_done) begin
        for (int i = 0; i < REGIONS - 1; i++) max_r[i] <= max_r[i+1];
        max_r[REGIONS-1] <= '0;
      end
      case (state_r)
        B_IDLE: begin
          item_r   <= '0;
          part_r   <= '0;
          cnt_r    <= '0;
          region_r <= '0;
          thr_r    <= {1'b0, cfg.span};
        end
        B_UPD: begin
          item_r  <= '0;
          part_r  <= '0;
          roll_r  <= acc_r[0];
          chunk_r <= acc_r[1];
          if (acc_r[0] > max_r[region_r]) max_r[region_r] <= acc_r[0];
        end
        // chunk hash is handed to the output, next chunk starts from zero
        B_DRAIN: if (out_load) chunk_r <= '0;
        default: ;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_chunk_start     = out_start_r;
  assign out_chunk_hash      = out_hash_r;
  assign out_super_feature_0 = out_sf_r[0];
  assign out_super_feature_1 = out_sf_r[1];
  assign out_super_feature_2 = out_sf_r[2];

`ifndef SYNTH
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == B_IDLE)) else $error("pop outside idle");
  a_region_max: assert property (@(posedge clk) disable iff (!rst_n)
    region_r <= 4'd11) else $error("region index out of range");
  a_upd_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_UPD) |-> ($past(state_r) == B_MUL)) else $error("update without multiply");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_hash_r)))
    else $error("stalled word changed");
`endif

endmodule

FILE: rtl/core/rolling_hash_chunk_super_features_top.sv
// top level: config registers, front end, queue and back end
// Each byte runs through the back end as 9 partial products on one shared
// 32x32 multiplier plus region search and update; the front waits a state after each byte.
// A chunk's last byte adds a pass over the 12 weighted maxima before its result
// is registered at the output; a held result stalls the back only once the next
// one is ready.
// Reset (rst_n, synchronous, active low) restores register defaults and clears
// all hash state at once; the window store is marked empty by valid bits.
module rolling_hash_chunk_super_features_top import rhcsf_pkg::*; #(
  parameter int WINDOW_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wen,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [47:0] out_chunk_start,
  output logic [63:0] out_chunk_hash,
  output logic [63:0] out_super_feature_0,
  output logic [63:0] out_super_feature_1,
  output logic [63:0] out_super_feature_2
);

  logic [63:0]      mult_r, drop_r;
  logic [15:0]      chunk_r;
  logic [3:0][63:0] weight_r;
  logic [29:0]      span_prod;
  logic [15:0]      span;
  cfg_t             cfg;
  logic             q_push, q_pop, q_full, q_empty;
  word_t            q_wdata, q_rdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_r   <= 64'd153191;
      drop_r   <= 64'd0;
      chunk_r  <= 16'd8192;
      weight_r <= {4{64'd1}};
    end else if (cfg_wen) begin
      unique case (cfg_index)
        CFG_HASH_MULT: mult_r      <= cfg_wdata;
        CFG_DROP:      drop_r      <= cfg_wdata;
        CFG_CHUNK:     chunk_r     <= cfg_wdata[15:0];
        CFG_WEIGHT_0:  weight_r[0] <= cfg_wdata;
        CFG_WEIGHT_1:  weight_r[1] <= cfg_wdata;
        CFG_WEIGHT_2:  weight_r[2] <= cfg_wdata;
        CFG_WEIGHT_3:  weight_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // region span: chunk length / 12 as (x / 4) / 3 by reciprocal, never zero
  assign span_prod = {16'd0, chunk_r[15:2]} * 30'd43691;
  assign span      = (span_prod[29:17] == 13'd0) ? 16'd1 : {3'd0, span_prod[29:17]};

  assign cfg.mult   = mult_r;
  assign cfg.drop   = drop_r;
  assign cfg.span   = span;
  assign cfg.weight = weight_r;

  rhcsf_front #(.WINDOW_BYTES(WINDOW_BYTES)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data_byte(in_data_byte),
    .chunk_bytes (chunk_r),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_wdata     (q_wdata)
  );

  rhcsf_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(q_wdata),
    .pop  (q_pop),
    .rdata(q_rdata),
    .full (q_full),
    .empty(q_empty)
  );

  rhcsf_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .q_empty            (q_empty),
    .q_rdata            (q_rdata),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_chunk_start    (out_chunk_start),
    .out_chunk_hash     (out_chunk_hash),
    .out_super_feature_0(out_super_feature_0),
    .out_super_feature_1(out_super_feature_1),
    .out_super_feature_2(out_super_feature_2)
  );

endmodule

FILE: tb/sv/tb_top.sv
// testbench for the rolling hash chunker with super-features
`timescale 1ns / 1ps

module tb_top;
  import rhcsf_pkg::*;

  localparam int WIN = 32;
  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE = 80;

  typedef struct packed {
    logic [47:0] start;
    logic [63:0] hash;
    logic [63:0] sf0;
    logic [63:0] sf1;
    logic [63:0] sf2;
  } chunk_sum_t;

  typedef struct packed {
    logic [7:0] data;
    logic       typed;
    chunk_sum_t sum;
  } byte_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wen = 1'b0;
  logic [2:0]  cfg_index = CFG_HASH_MULT;
  logic [63:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [47:0] out_chunk_start;
  logic [63:0] out_chunk_hash;
  logic [63:0] out_super_feature_0;
  logic [63:0] out_super_feature_1;
  logic [63:0] out_super_feature_2;

  rolling_hash_chunk_super_features_top i_dut (.*);

  always #4 clk = ~clk;

  // model state and register copies
  logic [63:0] mult_q, drop_q, weight_q [4];
  logic [15:0] chunk_len_q;
  logic [7:0]  window_q [WIN];
  int          slot_q;
  logic [63:0] roll_q, chunk_hash_q;
  logic [15:0] fill_q;
  logic [47:0] seen_q;
  logic [63:0] maxima_q [12];

  chunk_sum_t pending_sums [$];
  int  fails = 0;
  bit  quiet = 0;
  bit  hold_req = 0;
  bit  sender_gaps = 0;

  function automatic logic [63:0] sext(logic [7:0] b);
    return {{56{b[7]}}, b};
  endfunction

  function automatic void clear_chunk_state();
    chunk_hash_q = '0;
    fill_q = '0;
    foreach (maxima_q[i]) maxima_q[i] = '0;
  endfunction

  // advance the chunker by one byte; returns 1 when a chunk closes
  function automatic bit hash_byte(logic [7:0] b, output chunk_sum_t sum);
    logic [63:0] oldv, span, region, acc;
    oldv = sext(window_q[slot_q]);
    window_q[slot_q] = b;
    roll_q = roll_q * mult_q + sext(b) - oldv * drop_q;
    chunk_hash_q = chunk_hash_q * mult_q + sext(b);
    span = 64'(chunk_len_q) / 12;
    if (span == 0) span = 1;
    region = 64'(fill_q) / span;
    if (region > 11) region = 11;
    if (roll_q > maxima_q[region]) maxima_q[region] = roll_q;
    slot_q = (slot_q + 1) % WIN;
    seen_q = seen_q + 1;
    fill_q = fill_q + 1;
    sum = '0;
    if (fill_q != chunk_len_q) return 0;
    sum.start = seen_q - 48'(fill_q);
    sum.hash = chunk_hash_q;
    for (int k = 0; k < 3; k++) begin
      acc = '0;
      for (int i = 0; i < 4; i++) acc += maxima_q[k*4+i] * weight_q[i];
      if (k == 0) sum.sf0 = acc;
      else if (k == 1) sum.sf1 = acc;
      else sum.sf2 = acc;
    end
    clear_chunk_state();
    return 1;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_HASH_MULT: mult_q = val;
      CFG_DROP:      drop_q = val;
      CFG_CHUNK:     chunk_len_q = val[15:0];
      CFG_WEIGHT_0:  weight_q[0] = val;
      CFG_WEIGHT_1:  weight_q[1] = val;
      CFG_WEIGHT_2:  weight_q[2] = val;
      CFG_WEIGHT_3:  weight_q[3] = val;
      default: ;
    endcase
  endtask

  // offer one byte and hold it until taken
  task automatic send_byte(logic [7:0] b, bit typed = 0, chunk_sum_t typed_sum = '0);
    chunk_sum_t sum;
    in_valid <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall);
    if (hash_byte(b, sum)) pending_sums.push_back(typed ? typed_sum : sum);
    if (sender_gaps && !quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // wait for the chunker to go idle before touching registers
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [63:0] pick64();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 64'd1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hff;
      2: return 8'h80;
      3: return 8'h7f;
      default: return 8'($urandom);
    endcase
  endfunction

  // result checker
  always @(posedge clk) begin
    chunk_sum_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_sums.size() == 0) begin
        $error("unexpected result word start %h", out_chunk_start);
        fails++;
      end else begin
        e = pending_sums.pop_front();
        if (out_chunk_start !== e.start) begin
          $error("chunk_start exp %h got %h", e.start, out_chunk_start); fails++;
        end
        if (out_chunk_hash !== e.hash) begin
          $error("chunk_hash exp %h got %h", e.hash, out_chunk_hash); fails++;
        end
        if (out_super_feature_0 !== e.sf0) begin
          $error("super_feature_0 exp %h got %h", e.sf0, out_super_feature_0); fails++;
        end
        if (out_super_feature_1 !== e.sf1) begin
          $error("super_feature_1 exp %h got %h", e.sf1, out_super_feature_1); fails++;
        end
        if (out_super_feature_2 !== e.sf2) begin
          $error("super_feature_2 exp %h got %h", e.sf2, out_super_feature_2); fails++;
        end
      end
    end
  end

  // receiver stall bursts, with one long hold-off on request
  initial begin
    forever begin
      if (quiet || !rst_n) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (hold_req) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        hold_req = 0;
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
    end
  end

  // watchdog on cycles with no handshake at all
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wen || !rst_n)
      idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  byte_row_t rows [] = '{
    '{8'hff, 1'b1, '{48'd0, '1, '1, 64'd0, 64'd0}},
    '{8'h00, 1'b0, '0}, '{8'h7f, 1'b0, '0}, '{8'h80, 1'b0, '0},
    '{8'h01, 1'b0, '0}, '{8'hfe, 1'b0, '0}, '{8'h55, 1'b0, '0},
    '{8'haa, 1'b0, '0}, '{8'hff, 1'b0, '0}, '{8'hff, 1'b0, '0},
    '{8'h80, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h7f, 1'b0, '0},
    '{8'h01, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'hc3, 1'b0, '0}
  };

  initial begin
    logic [63:0] m, p;
    int n;
    // reset values of the model
    mult_q = 64'd153191;
    drop_q = '0;
    chunk_len_q = 16'd8192;
    foreach (weight_q[i]) weight_q[i] = 64'd1;
    foreach (window_q[i]) window_q[i] = '0;
    slot_q = 0; roll_q = '0; seen_q = '0;
    clear_chunk_state();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: one byte per chunk, then a short chunk length
    write_reg(CFG_CHUNK, 64'd1);
    foreach (rows[i]) send_byte(rows[i].data, rows[i].typed, rows[i].sum);
    drain();
    write_reg(CFG_CHUNK, 64'd5);
    write_reg(CFG_DROP, '1);
    for (int i = 0; i < 10; i++) send_byte(pick_byte());
    drain();

    // random phases with varied settings
    for (int ph = 0; ph < 8; ph++) begin
      m = (ph == 0) ? 64'd0 : (ph == 1) ? '1 : pick64();
      p = 64'd1;
      for (int i = 0; i < WIN; i++) p = p * m;
      write_reg(CFG_HASH_MULT, m);
      write_reg(CFG_DROP, ($urandom_range(0, 4) == 0) ? pick64() : p);
      case (ph)
        0: n = 12;
        1: n = 13;
        2: n = 3;
        3: n = 4;
        default: n = $urandom_range(1, 40);
      endcase
      write_reg(CFG_CHUNK, 64'(n));
      write_reg(CFG_WEIGHT_0, pick64());
      write_reg(CFG_WEIGHT_1, pick64());
      write_reg(CFG_WEIGHT_2, pick64());
      write_reg(CFG_WEIGHT_3, pick64());
      sender_gaps = (ph % 3 != 1);
      if (ph == 3) hold_req = 1;
      for (int i = 0; i < 170; i++) send_byte(pick_byte());
      drain();
    end

    // zero chunk length: no word comes out, regions clamp at the last one
    quiet = 1;
    write_reg(CFG_CHUNK, 64'd0);
    for (int i = 0; i < 30; i++) send_byte(8'($urandom));
    drain();

    if (fails == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
